### hdl/i2r_pkg.sv
// Shared types, constants and symbol tables for the integer to Roman numeral converter.
package i2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NDIGITS  = 4;
    localparam int unsigned BCD_W    = DIGIT_W * NDIGITS;
    localparam int unsigned SYMBOL_W = 8;

    localparam logic [VALUE_W-1:0]  MAX_VALUE = 12'd3999;
    localparam logic [3:0]          LAST_BIT  = 4'(VALUE_W - 1);

    localparam logic [SYMBOL_W-1:0] CH_I = 8'h49;
    localparam logic [SYMBOL_W-1:0] CH_V = 8'h56;
    localparam logic [SYMBOL_W-1:0] CH_X = 8'h58;
    localparam logic [SYMBOL_W-1:0] CH_L = 8'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_D = 8'h44;
    localparam logic [SYMBOL_W-1:0] CH_M = 8'h4D;
    localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;

    // Digit positions, most significant first
    localparam logic [1:0] POS_THOU = 2'd0;
    localparam logic [1:0] POS_HUND = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_UNIT = 2'd3;

    typedef enum logic [1:0] {
        K_ONE,
        K_FIVE,
        K_TEN
    } t_kind;

    // Datapath commands from the controller
    typedef struct packed {
        logic load;     // capture input value
        logic shift;    // one binary-to-BCD step
        logic seek;     // point at the first nonzero digit
        logic step;     // emit one character
        logic special;  // emit the single no-symbol result
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic oor;
        logic zero;
        logic conv_done;
        logic char_last;
    } t_dp_sts;

    // Characters produced by a hundreds/tens/units digit
    function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Which of the one/five/ten symbols is character j of digit d
    function automatic t_kind sym_kind(input logic [1:0] pos, input logic [DIGIT_W-1:0] d,
                                       input logic [1:0] j);
        t_kind k;
        k = K_ONE;
        if (pos != POS_THOU) begin
            if (d == 4'd9) begin
                k = (j == 2'd0) ? K_ONE : K_TEN;
            end else if (d == 4'd4) begin
                k = (j == 2'd0) ? K_ONE : K_FIVE;
            end else if (d >= 4'd5) begin
                k = (j == 2'd0) ? K_FIVE : K_ONE;
            end
        end
        return k;
    endfunction

    function automatic logic [SYMBOL_W-1:0] sym_char(input logic [1:0] pos, input t_kind k);
        logic [SYMBOL_W-1:0] c;
        case (pos)
            POS_THOU: c = CH_M;
            POS_HUND: c = (k == K_ONE) ? CH_C : ((k == K_FIVE) ? CH_D : CH_M);
            POS_TENS: c = (k == K_ONE) ? CH_X : ((k == K_FIVE) ? CH_L : CH_C);
            POS_UNIT: c = (k == K_ONE) ? CH_I : ((k == K_FIVE) ? CH_V : CH_X);
            default:  c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

### hdl/integer_to_roman_numeral_top.sv
// Top level of the integer to Roman numeral converter: controller plus datapath.
//
//  channel   handshake            payload
//  --------  -------------------  ----------------------------------------------
//  input     start & !busy        i_value[11:0]
//  result    o_valid (1 cycle)    o_symbol[7:0], o_last, o_no_symbol, o_out_of_range
//
// One transfer per input; zero or above-3999 gives its single result
// from the check state. Otherwise a shift-add-3 BCD conversion, one shift
// per input bit, and a digit seek precede the characters, one per cycle;
// the longest numeral, for 3888, has 15 characters.
// busy is high from the cycle after the transfer until the last result is
// registered. Reset is synchronous, active low, on i_rst_n.
// The receiver cannot stall: each result is valid for exactly one cycle.
module integer_to_roman_numeral_top
    import i2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_no_symbol,
    output logic                o_out_of_range
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    ctl_start;

    // Accept only when idle; the controller sees start gated by busy
    assign ctl_start = start && !busy;

    i2r_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (ctl_start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    i2r_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_no_symbol    (o_no_symbol),
        .o_out_of_range (o_out_of_range)
    );

`ifndef NO_ASSERTIONS
    // A transfer always makes the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after input transfer");

    // Characters of one numeral come out on consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a numeral");

    // The final result appears only once the block is idle again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("last result while still busy");

    // A no-symbol result stands alone and carries no character
    a_nosym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_symbol |-> o_last && (o_symbol == CH_NONE))
        else $error("malformed no-symbol result");

    // Range flag only on no-symbol results
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_no_symbol)
        else $error("out_of_range without no_symbol");
`endif

endmodule

### hdl/i2r_ctrl.sv
// Controller state machine: sequences load, BCD conversion and character emission.
module i2r_ctrl
    import i2r_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CONV,
        S_SEEK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.oor || i_sts.zero) begin
                    o_cmd.special = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                o_cmd.seek = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.step = 1'b1;
                if (i_sts.char_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

### hdl/i2r_dpath.sv
// Datapath: value register, shift-add-3 BCD converter, digit walker and result registers.
module i2r_dpath
    import i2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VALUE_W-1:0]  i_value,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic                o_valid,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_no_symbol,
    output logic                o_out_of_range
);

    logic [VALUE_W-1:0]  r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [3:0]          r_cnt;
    logic [1:0]          r_pos;
    logic [1:0]          r_j;
    logic                r_valid;
    logic [SYMBOL_W-1:0] r_symbol;
    logic                r_last;
    logic                r_no_symbol;
    logic                r_oor;

    logic [BCD_W-1:0]    n_bcd;
    logic [BCD_W-1:0]    adj;
    logic [DIGIT_W-1:0]  digit [NDIGITS];
    logic [NDIGITS-1:0]  nz;
    logic [DIGIT_W-1:0]  cur_d;
    logic [2:0]          cur_len;
    logic                digit_end;
    logic                more;
    logic [1:0]          next_pos;
    logic [1:0]          first_pos;
    logic [SYMBOL_W-1:0] cur_char;

    // Add 3 to every BCD digit of 5 or more, then shift in the next binary bit
    always_comb begin
        for (int i = 0; i < NDIGITS; i++) begin
            adj[i*DIGIT_W +: DIGIT_W] = (r_bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                                      ? r_bcd[i*DIGIT_W +: DIGIT_W] + 4'd3
                                      : r_bcd[i*DIGIT_W +: DIGIT_W];
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
    end

    // Position 0 is the thousands digit
    always_comb begin
        for (int p = 0; p < NDIGITS; p++) begin
            digit[p] = r_bcd[(NDIGITS-1-p)*DIGIT_W +: DIGIT_W];
            nz[p]    = (digit[p] != '0);
        end
    end

    always_comb begin
        cur_d     = digit[r_pos];
        cur_len   = (r_pos == POS_THOU) ? cur_d[2:0] : digit_len(cur_d);
        digit_end = ({1'b0, r_j} == cur_len - 3'd1);
        more      = 1'b0;
        next_pos  = r_pos;
        for (int p = NDIGITS - 1; p >= 0; p--) begin
            if (nz[p] && (2'(p) > r_pos)) begin
                more     = 1'b1;
                next_pos = 2'(p);
            end
        end
        first_pos = POS_UNIT;
        for (int p = NDIGITS - 1; p >= 0; p--) begin
            if (nz[p]) begin
                first_pos = 2'(p);
            end
        end
        cur_char = sym_char(r_pos, sym_kind(r_pos, cur_d, r_j));
    end

    assign o_sts.oor       = (r_bin > MAX_VALUE);
    assign o_sts.zero      = (r_bin == '0);
    assign o_sts.conv_done = (r_cnt == LAST_BIT);
    assign o_sts.char_last = digit_end && !more;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step || i_cmd.special;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= n_bcd;
            r_cnt <= r_cnt + 4'd1;
        end
        if (i_cmd.seek) begin
            r_pos <= first_pos;
            r_j   <= '0;
        end else if (i_cmd.step) begin
            if (digit_end) begin
                r_pos <= next_pos;
                r_j   <= '0;
            end else begin
                r_j <= r_j + 2'd1;
            end
        end
        if (i_cmd.special) begin
            r_symbol    <= CH_NONE;
            r_last      <= 1'b1;
            r_no_symbol <= 1'b1;
            r_oor       <= o_sts.oor;
        end else if (i_cmd.step) begin
            r_symbol    <= cur_char;
            r_last      <= o_sts.char_last;
            r_no_symbol <= 1'b0;
            r_oor       <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol       = r_symbol;
    assign o_last         = r_last;
    assign o_no_symbol    = r_no_symbol;
    assign o_out_of_range = r_oor;

endmodule

### dv/tb_top.sv
// Self-checking testbench for integer_to_roman_numeral_top, checked per character.
module tb_top
    import i2r_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // A quiet spell can last through a job's longest idle gap plus one
    // conversion; STALL_LIMIT lies well above that, so reaching it means the block is stuck.
    localparam int STALL_LIMIT = 500;
    // Covers the worst case from a transfer to its last character (input 3888)
    localparam int DRAIN_CYCLES = 40;

    // One expected character (or flag-only) result
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                no_symbol;
        logic                out_of_range;
    } t_glyph;

    // One value to convert, with the idle cycles that follow its transfer
    typedef struct {
        logic [VALUE_W-1:0] value;
        int                 gap;
    } t_job;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  i_value;
    logic                o_valid;
    logic [SYMBOL_W-1:0] o_symbol;
    logic                o_last;
    logic                o_no_symbol;
    logic                o_out_of_range;

    t_job   job_q[$];       // values waiting to be driven
    t_glyph numeral_q[$];   // characters still owed by the block
    int     errors    = 0;
    logic   took      = 1'b0;  // value transfer at the latest rising edge
    int     quiet     = 0;     // cycles without any transfer or result

    integer_to_roman_numeral_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_no_symbol    (o_no_symbol),
        .o_out_of_range (o_out_of_range)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Expected result stream for one value: decimal digits, most significant
    // first, each spelled with its one/five/ten letters.
    function automatic void spell_roman(input logic [VALUE_W-1:0] v);
        logic [SYMBOL_W-1:0] ones_ch[4];
        logic [SYMBOL_W-1:0] fives_ch[4];
        logic [SYMBOL_W-1:0] tens_ch[4];
        logic [SYMBOL_W-1:0] chars[$];
        int                  dig[4];
        int                  num;
        int                  d;
        t_glyph              g;

        ones_ch  = '{CH_M, CH_C, CH_X, CH_I};
        fives_ch = '{CH_NONE, CH_D, CH_L, CH_V};
        tens_ch  = '{CH_NONE, CH_M, CH_C, CH_X};
        num = int'(v);

        if (v > MAX_VALUE) begin
            g = '{CH_NONE, 1'b1, 1'b1, 1'b1};
            numeral_q = {numeral_q, g};
        end else if (v == '0) begin
            g = '{CH_NONE, 1'b1, 1'b1, 1'b0};
            numeral_q = {numeral_q, g};
        end else begin
            dig[0] = num / 1000;
            dig[1] = (num / 100) % 10;
            dig[2] = (num / 10) % 10;
            dig[3] = num % 10;
            // thousands never exceed 3, so they fall into the plain repeat branch
            for (int p = 0; p < 4; p++) begin
                d = dig[p];
                if (d == 9) begin
                    chars = {chars, ones_ch[p], tens_ch[p]};
                end else if (d == 4) begin
                    chars = {chars, ones_ch[p], fives_ch[p]};
                end else if (d >= 5) begin
                    chars = {chars, fives_ch[p]};
                    for (int i = 5; i < d; i++) chars = {chars, ones_ch[p]};
                end else begin
                    for (int i = 0; i < d; i++) chars = {chars, ones_ch[p]};
                end
            end
            foreach (chars[k]) begin
                g = '{chars[k], (k == chars.size() - 1), 1'b0, 1'b0};
                numeral_q = {numeral_q, g};
            end
        end
    endfunction

    // Driver: changes inputs on the falling edge. start stays high until the
    // block takes the value, then the job's gap of idle cycles follows.
    int                 hold_off = 0;
    int                 cur_gap  = 0;
    always @(negedge i_clk) begin : drive
        logic               next_start;
        logic [VALUE_W-1:0] next_value;
        t_job               job;

        next_start = start;
        next_value = i_value;
        if (i_rst_n) begin
            if (start && took) hold_off = cur_gap;
            if (!start || took) begin
                if (hold_off > 0) begin
                    // idle cycle: junk on the value port must be ignored
                    next_start = 1'b0;
                    next_value = VALUE_W'($urandom_range(0, 4095));
                    hold_off--;
                end else if (job_q.size() > 0) begin
                    job        = job_q.pop_front();
                    next_start = 1'b1;
                    next_value = job.value;
                    cur_gap    = job.gap;
                end else begin
                    next_start = 1'b0;
                end
            end
        end else begin
            next_start = 1'b0;
        end
        start   <= next_start;
        i_value <= next_value;
    end

    // Monitor: samples at the rising edge, records value transfers, checks
    // every strobed result against the oldest owed character, and guards
    // against a hang.
    always @(posedge i_clk) begin : observe
        t_glyph want;
        t_glyph got;

        took = i_rst_n && start && !busy;
        if (i_rst_n && o_valid) begin
            got = '{o_symbol, o_last, o_no_symbol, o_out_of_range};
            if (numeral_q.size() == 0) begin
                $display("%0t: unexpected result sym=%h last=%b none=%b oor=%b",
                         $time, got.symbol, got.last, got.no_symbol, got.out_of_range);
                errors++;
            end else begin
                want = numeral_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch exp sym=%h last=%b none=%b oor=%b,%s",
                             $time, want.symbol, want.last, want.no_symbol,
                             want.out_of_range, " got");
                    $display("%0t:          got sym=%h last=%b none=%b oor=%b",
                             $time, got.symbol, got.last, got.no_symbol,
                             got.out_of_range);
                    errors++;
                end
            end
        end
        if (took) spell_roman(i_value);

        if (took || (i_rst_n && o_valid)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("integer_to_roman_numeral_top test failed");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin : stimulus
        logic [VALUE_W-1:0] directed[25];
        t_job               job;
        int                 pick;
        int                 g;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;

        // Letter extremes, subtractive forms, longest numeral, range edges,
        // all-zero and all-one input bits
        directed = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9,
                     12'd10, 12'd40, 12'd49, 12'd90, 12'd99, 12'd400, 12'd444,
                     12'd500, 12'd900, 12'd999, 12'd1000, 12'd1994, 12'd3888,
                     12'd3999, 12'd4000, 12'd4095, 12'd2730};
        foreach (directed[k]) begin
            job.value = directed[k];
            job.gap   = (k % 3 == 0) ? 0 : k;
            job_q = {job_q, job};
        end

        for (int n = 0; n < 480; n++) begin
            pick = $urandom_range(0, 9);
            case (pick) inside
                0:       job.value = VALUE_W'($urandom_range(0, 4095));
                1:       job.value = VALUE_W'($urandom_range(4000, 4095));
                2:       job.value = VALUE_W'($urandom_range(1, 99));
                [3:5]:   job.value = VALUE_W'($urandom_range(0, 3) * 1000
                                             + $urandom_range(0, 9) * 100
                                             + $urandom_range(0, 9) * 10
                                             + $urandom_range(0, 9));
                default: job.value = VALUE_W'($urandom_range(1, 3999));
            endcase
            // every fourth block of 32 runs back to back
            g = $urandom_range(0, 99);
            if ((n / 32) % 4 == 3) job.gap = 0;
            else if (g < 50)       job.gap = 0;
            else if (g < 90)       job.gap = $urandom_range(1, 3);
            else                   job.gap = $urandom_range(10, 45);
            job_q = {job_q, job};
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || start || numeral_q.size() != 0) @(negedge i_clk);
        // catch any stray results after the last owed one
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("integer_to_roman_numeral_top test passed");
        end else begin
            $display("integer_to_roman_numeral_top test failed");
        end
        $finish;
    end

endmodule
